/* hw/rtl/odm_pkg.sv */
// ----------------------------------------------------------------------------
// odm_pkg - shared types and constants for the ordered dither block
// Word layouts, configuration map, queue entry and built-in pattern ROMs.
// ----------------------------------------------------------------------------
package odm_pkg;

	// field widths fixed by the interface
	localparam int PIXELS_W     = 32;
	localparam int IDX_W        = 8;
	localparam int BYTE_W       = 8;
	localparam int ROW_BYTES_W  = 10;
	localparam int FRAME_ROWS_W = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 13;

	// phase and pattern row fields are sized for the largest pattern height (16)
	localparam int PHASE_W  = 4;
	localparam int WR_ROW_W = 4;
	localparam int WR_BYTE_W = 4;

	localparam int LEVELS2 = 4;
	localparam int LEVELS4 = 16;
	localparam int ROM_PHASES = 8;

	localparam int QUEUE_DEPTH = 4;

	// parameter defaults
	localparam int DEF_PATTERN_ROWS   = 8;
	localparam int DEF_MAX_ROW_BYTES  = 512;
	localparam int DEF_MAX_FRAME_ROWS = 4096;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_4   = 3'd4;

	// item kinds
	localparam logic KIND_PIXELS = 1'b0;
	localparam logic KIND_TABLE  = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [PIXELS_W-1:0] pixels;
		logic [IDX_W-1:0]    table_index;
		logic [BYTE_W-1:0]   table_value;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_row;
		logic              last_of_frame;
	} result_t;

	typedef struct packed {
		logic                    depth_mode;
		logic [ROW_BYTES_W-1:0]  row_bytes;
		logic [FRAME_ROWS_W-1:0] frame_rows;
		logic                    custom_2bit;
		logic                    custom_4bit;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_PIXELS = 2'd0,
		OP_WR2    = 2'd1,
		OP_WR4    = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [PIXELS_W-1:0]  pixels;
		logic [PHASE_W-1:0]   phase;
		logic                 last_of_row;
		logic                 last_of_frame;
		logic [WR_ROW_W-1:0]  wr_row;
		logic [WR_BYTE_W-1:0] wr_byte;
		logic [BYTE_W-1:0]    wr_value;
	} entry_t;

	localparam logic [BYTE_W-1:0] ROM2 [ROM_PHASES][LEVELS2] = '{
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hEE, 8'hFF},
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hBB, 8'hFF},
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hEE, 8'hFF},
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hBB, 8'hFF}
	};

	localparam logic [BYTE_W-1:0] ROM4 [ROM_PHASES][LEVELS4] = '{
		'{8'h00,8'h00,8'h22,8'h22,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hEE,8'hEE,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h11,8'h11,8'h55,
		  8'h55,8'h55,8'h55,8'hDD,8'hDD,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h88,8'h88,8'hAA,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hBB,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h44,8'h55,
		  8'h55,8'h55,8'h55,8'h55,8'h77,8'h77,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h22,8'h22,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hEE,8'hEE,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h11,8'h11,8'h55,
		  8'h55,8'h55,8'h55,8'hDD,8'hDD,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h88,8'h88,8'hAA,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hBB,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h44,8'h55,
		  8'h55,8'h55,8'h55,8'h55,8'h77,8'h77,8'hFF,8'hFF}
	};

endpackage

/* hw/rtl/odm_front.sv */
// ----------------------------------------------------------------------------
// odm_front - input side of the ordered dither block
// Accepts words, tracks column, row and pattern phase, decodes table writes
// and pushes one queue entry per word that has work to do.
// ----------------------------------------------------------------------------
module odm_front #(
	parameter int PATTERN_ROWS   = odm_pkg::DEF_PATTERN_ROWS,
	parameter int MAX_ROW_BYTES  = odm_pkg::DEF_MAX_ROW_BYTES,
	parameter int MAX_FRAME_ROWS = odm_pkg::DEF_MAX_FRAME_ROWS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  odm_pkg::cfg_t   cfg,
	input  logic            item_valid,
	output logic            item_stall,
	input  odm_pkg::item_t  item,
	output logic            push,
	output odm_pkg::entry_t push_entry,
	input  logic            push_ready
);
	import odm_pkg::*;

	localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int ROW_W = (MAX_FRAME_ROWS > 1) ? $clog2(MAX_FRAME_ROWS) : 1;
	localparam int EC_W  = ($clog2(MAX_ROW_BYTES + 1) > ROW_BYTES_W) ?
		$clog2(MAX_ROW_BYTES + 1) : ROW_BYTES_W;
	localparam int ER_W  = ($clog2(MAX_FRAME_ROWS + 1) > FRAME_ROWS_W) ?
		$clog2(MAX_FRAME_ROWS + 1) : FRAME_ROWS_W;
	localparam int PH_W  = $clog2(PATTERN_ROWS);
	localparam int TABLE2_SIZE = 4 * PATTERN_ROWS;
	localparam int STORE_SIZE  = 20 * PATTERN_ROWS;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PH_W-1:0]  phase_q;

	logic [EC_W-1:0] rb_x, eff_cols, col_inc;
	logic [ER_W-1:0] fr_x, eff_rows, row_inc;
	logic            end_row, end_frame;
	logic            accept, is_pixels, is_wr2, is_wr4;
	logic [IDX_W-1:0] off4;

	// zero acts as one, oversize saturates
	always_comb begin
		rb_x = EC_W'(cfg.row_bytes);
		fr_x = ER_W'(cfg.frame_rows);
		if (rb_x == '0) begin
			eff_cols = EC_W'(1);
		end else if (rb_x > EC_W'(MAX_ROW_BYTES)) begin
			eff_cols = EC_W'(MAX_ROW_BYTES);
		end else begin
			eff_cols = rb_x;
		end
		if (fr_x == '0) begin
			eff_rows = ER_W'(1);
		end else if (fr_x > ER_W'(MAX_FRAME_ROWS)) begin
			eff_rows = ER_W'(MAX_FRAME_ROWS);
		end else begin
			eff_rows = fr_x;
		end
	end

	assign col_inc   = EC_W'(col_q) + EC_W'(1);
	assign row_inc   = ER_W'(row_q) + ER_W'(1);
	assign end_row   = (col_inc >= eff_cols);
	assign end_frame = end_row && (row_inc >= eff_rows);

	assign item_stall = !push_ready;
	assign accept     = item_valid && push_ready;
	assign is_pixels  = (item.kind == KIND_PIXELS);
	assign is_wr2     = !is_pixels && (32'(item.table_index) < TABLE2_SIZE);
	assign is_wr4     = !is_pixels && !is_wr2 && (32'(item.table_index) < STORE_SIZE);
	assign off4       = item.table_index - IDX_W'(TABLE2_SIZE);

	// out-of-range table writes are dropped here
	assign push = accept && (is_pixels || is_wr2 || is_wr4);

	always_comb begin
		push_entry               = '0;
		push_entry.pixels        = item.pixels;
		push_entry.phase         = PHASE_W'(phase_q);
		push_entry.last_of_row   = end_row;
		push_entry.last_of_frame = end_frame;
		push_entry.wr_value      = item.table_value;
		if (is_pixels) begin
			push_entry.op = OP_PIXELS;
		end else if (is_wr2) begin
			push_entry.op      = OP_WR2;
			push_entry.wr_row  = WR_ROW_W'(item.table_index >> 2);
			push_entry.wr_byte = WR_BYTE_W'(item.table_index[1:0]);
		end else begin
			push_entry.op      = OP_WR4;
			push_entry.wr_row  = WR_ROW_W'(off4 >> 4);
			push_entry.wr_byte = off4[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (accept && is_pixels) begin
			if (end_row) begin
				col_q <= '0;
				if (end_frame) begin
					row_q   <= '0;
					phase_q <= '0;
				end else begin
					row_q   <= ROW_W'(row_inc);
					phase_q <= (phase_q == PH_W'(PATTERN_ROWS - 1)) ? '0 : phase_q + PH_W'(1);
				end
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

endmodule

/* hw/rtl/odm_queue.sv */
// ----------------------------------------------------------------------------
// odm_queue - short queue between front and back
// Lets the front keep accepting while the back waits on the receiver.
// ----------------------------------------------------------------------------
module odm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  odm_pkg::entry_t push_entry,
	output logic            push_ready,
	input  logic            pop,
	output logic            head_valid,
	output odm_pkg::entry_t head
);
	import odm_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/odm_back.sv */
// ----------------------------------------------------------------------------
// odm_back - pattern lookup and output side
// Applies table writes to the loaded pattern store, reads one pattern row
// per pixel word, selects a bit per pixel and holds the result word.
// ----------------------------------------------------------------------------
module odm_back #(
	parameter int PATTERN_ROWS = odm_pkg::DEF_PATTERN_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  odm_pkg::cfg_t    cfg,
	input  logic             head_valid,
	input  odm_pkg::entry_t  head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output odm_pkg::result_t result
);
	import odm_pkg::*;

	localparam int RA_W = $clog2(PATTERN_ROWS);

	// one row per phase, all entries of that phase side by side
	logic [LEVELS2-1:0][BYTE_W-1:0] tab2_mem [PATTERN_ROWS];
	logic [LEVELS4-1:0][BYTE_W-1:0] tab4_mem [PATTERN_ROWS];

	logic [LEVELS2-1:0][BYTE_W-1:0] rd2_s1;
	logic [LEVELS4-1:0][BYTE_W-1:0] rd4_s1;
	logic                           valid_s1;
	logic [PIXELS_W-1:0]            pixels_s1;
	logic [PHASE_W-1:0]             phase_s1;
	logic                           last_row_s1, last_frame_s1;

	logic    out_ready, s1_ready, take_pixels;
	logic    [BYTE_W-1:0] dither;
	result_t result_q;
	logic    result_valid_q;

	assign out_ready   = !result_valid_q || !result_stall;
	assign s1_ready    = !valid_s1 || out_ready;
	assign pop         = head_valid && s1_ready;
	assign take_pixels = pop && (head.op == OP_PIXELS);

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (head.op)
				OP_WR2: tab2_mem[head.wr_row[RA_W-1:0]][head.wr_byte[1:0]] <= head.wr_value;
				OP_WR4: tab4_mem[head.wr_row[RA_W-1:0]][head.wr_byte] <= head.wr_value;
				default: ;
			endcase
		end
		if (take_pixels) begin
			rd2_s1 <= tab2_mem[head.phase[RA_W-1:0]];
			rd4_s1 <= tab4_mem[head.phase[RA_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (take_pixels) begin
			pixels_s1     <= head.pixels;
			phase_s1      <= head.phase;
			last_row_s1   <= head.last_of_row;
			last_frame_s1 <= head.last_of_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= take_pixels;
		end
	end

	// bit k of the entry picked by pixel k's level
	always_comb begin
		logic [1:0] lv2;
		logic [3:0] lv4;
		dither = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			lv2 = pixels_s1[2*k +: 2];
			lv4 = pixels_s1[4*k +: 4];
			if (!cfg.depth_mode) begin
				dither[k] = cfg.custom_2bit ? rd2_s1[lv2][k] : ROM2[phase_s1[2:0]][lv2][k];
			end else begin
				dither[k] = cfg.custom_4bit ? rd4_s1[lv4][k] : ROM4[phase_s1[2:0]][lv4][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_ready) begin
			result_q.out_byte      <= dither;
			result_q.last_of_row   <= last_row_s1;
			result_q.last_of_frame <= last_frame_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_ready) begin
			result_valid_q <= valid_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* hw/rtl/ordered_dither_to_mono.sv */
// ----------------------------------------------------------------------------
// ordered_dither_to_mono - grey to monochrome ordered dither
// Turns eight 2-bit or 4-bit grey pixels into one dithered output byte.
// ----------------------------------------------------------------------------
// item channel: item_valid / item_stall carry one word, either eight pixels
//   of one output byte or a single pattern table byte write (kind set).
//   Table writes and writes beyond the store give no result word.
// result channel: result_valid / result_stall carry the dithered byte with
//   row end and frame end marks, in input order.
// cfg channel: cfg_valid / cfg_ready with register index and data; cfg_ready
//   is always high. Write only while no words are in flight.
// An accepted word passes the queue, the pattern read stage and the result
//   register; throughput is one word per clock while the result side is free.
//   The pattern store is read once per pixel word.
// A stalled receiver holds the result register; a four entry queue keeps the
//   item side accepting until it fills, then item_stall rises.
// Reset clears column, row and phase, the queue and the valid flags, and
//   sets registers to 2-bit mode, one byte per row, one row per frame, built-in
//   tables. The loaded pattern store is not cleared.
module ordered_dither_to_mono #(
	parameter int PATTERN_ROWS   = odm_pkg::DEF_PATTERN_ROWS,
	parameter int MAX_ROW_BYTES  = odm_pkg::DEF_MAX_ROW_BYTES,
	parameter int MAX_FRAME_ROWS = odm_pkg::DEF_MAX_FRAME_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  odm_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output odm_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [odm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [odm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import odm_pkg::*;

	cfg_t   cfg_q;
	logic   push, push_ready, pop, head_valid;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_mode  <= 1'b0;
			cfg_q.row_bytes   <= ROW_BYTES_W'(1);
			cfg_q.frame_rows  <= FRAME_ROWS_W'(1);
			cfg_q.custom_2bit <= 1'b0;
			cfg_q.custom_4bit <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEPTH_MODE: cfg_q.depth_mode  <= cfg_data[0];
				REG_ROW_BYTES:  cfg_q.row_bytes   <= cfg_data[ROW_BYTES_W-1:0];
				REG_FRAME_ROWS: cfg_q.frame_rows  <= cfg_data[FRAME_ROWS_W-1:0];
				REG_CUSTOM_2:   cfg_q.custom_2bit <= cfg_data[0];
				REG_CUSTOM_4:   cfg_q.custom_4bit <= cfg_data[0];
				default: ;
			endcase
		end
	end

	odm_front #(
		.PATTERN_ROWS  (PATTERN_ROWS),
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.MAX_FRAME_ROWS(MAX_FRAME_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.push      (push),
		.push_entry(push_entry),
		.push_ready(push_ready)
	);

	odm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.push_ready(push_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	odm_back #(
		.PATTERN_ROWS(PATTERN_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - regression bench for ordered_dither_to_mono
// Streams pixel and pattern-table words through the block under random
// stalls on both sides and compares each dithered byte and its row/frame
// marks against an in-bench prediction of the dither and position tracking.
// ----------------------------------------------------------------------------
module tb;
	import odm_pkg::*;

	localparam int PATTERN_ROWS  = 8;
	localparam int MAX_COLS      = 512;
	localparam int MAX_ROWS      = 4096;
	localparam int STORE_BYTES   = 20 * PATTERN_ROWS;
	localparam int FLUSH_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	localparam bit [7:0] DITHER2_ROM [8][4] = '{
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hEE, 8'hFF},
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hBB, 8'hFF},
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hEE, 8'hFF},
		'{8'h00, 8'h55, 8'h55, 8'hFF}, '{8'h00, 8'hAA, 8'hBB, 8'hFF}
	};

	localparam bit [7:0] DITHER4_ROM [8][16] = '{
		'{8'h00,8'h00,8'h22,8'h22,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hEE,8'hEE,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h11,8'h11,8'h55,
		  8'h55,8'h55,8'h55,8'hDD,8'hDD,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h88,8'h88,8'hAA,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hBB,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h44,8'h55,
		  8'h55,8'h55,8'h55,8'h55,8'h77,8'h77,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h22,8'h22,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hEE,8'hEE,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h11,8'h11,8'h55,
		  8'h55,8'h55,8'h55,8'hDD,8'hDD,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h88,8'h88,8'hAA,8'hAA,8'hAA,8'hAA,8'hAA,
		  8'hBB,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h44,8'h55,
		  8'h55,8'h55,8'h55,8'h55,8'h77,8'h77,8'hFF,8'hFF}
	};

	class dither_scoreboard;
		bit              depth4;
		bit [9:0]        row_bytes;
		bit [12:0]       frame_rows;
		bit              custom2;
		bit              custom4;
		bit [8:0]        col;
		bit [11:0]       row;
		bit [7:0]        loaded_table [STORE_BYTES];
		result_t         expected_bytes [$];
		int              errors;
		int              checked;

		function new();
			depth4 = 1'b0;
			row_bytes = 10'd1;
			frame_rows = 13'd1;
			custom2 = 1'b0;
			custom4 = 1'b0;
			col = '0;
			row = '0;
			errors = 0;
			checked = 0;
			foreach (loaded_table[i]) loaded_table[i] = 8'h00;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DEPTH_MODE: depth4 = data[0];
				REG_ROW_BYTES:  row_bytes = data[ROW_BYTES_W-1:0];
				REG_FRAME_ROWS: frame_rows = data[FRAME_ROWS_W-1:0];
				REG_CUSTOM_2:   custom2 = data[0];
				REG_CUSTOM_4:   custom4 = data[0];
				default: ;
			endcase
		endfunction

		function bit [7:0] pattern_byte(int phase, int level);
			if (!depth4) begin
				if (custom2)
					return loaded_table[phase * 4 + level];
				return DITHER2_ROM[phase % 8][level];
			end
			if (custom4)
				return loaded_table[4 * PATTERN_ROWS + phase * 16 + level];
			return DITHER4_ROM[phase % 8][level];
		endfunction

		function void predict_word(item_t it);
			result_t   want;
			bit [7:0]  pat;
			int        phase;
			int        level;
			int        k;
			int        eff_cols;
			int        eff_rows;
			if (it.kind == KIND_TABLE) begin
				if (it.table_index < STORE_BYTES)
					loaded_table[it.table_index] = it.table_value;
				return;
			end
			want = '0;
			phase = row % PATTERN_ROWS;
			for (k = 0; k < 8; k++) begin
				if (depth4)
					level = (it.pixels >> (4 * k)) & 32'hF;
				else
					level = (it.pixels >> (2 * k)) & 32'h3;
				pat = pattern_byte(phase, level);
				want.out_byte[k] = pat[k];
			end
			eff_cols = (row_bytes == 0) ? 1 : ((row_bytes > MAX_COLS) ? MAX_COLS : row_bytes);
			eff_rows = (frame_rows == 0) ? 1 : ((frame_rows > MAX_ROWS) ? MAX_ROWS : frame_rows);
			// a position at or past a shrunk limit still counts as the last one
			if (int'(col) + 1 >= eff_cols) begin
				want.last_of_row = 1'b1;
				col = '0;
				want.last_of_frame = (int'(row) + 1 >= eff_rows);
				row = want.last_of_frame ? 12'd0 : row + 12'd1;
			end else begin
				col = col + 9'd1;
			end
			expected_bytes.push_back(want);
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (expected_bytes.size() == 0) begin
				$error("result word %h arrived with nothing expected", got);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			checked++;
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.last_of_row !== want.last_of_row) begin
				$error("last_of_row: expected %b, actual %b", want.last_of_row,
					got.last_of_row);
				errors++;
			end
			if (got.last_of_frame !== want.last_of_frame) begin
				$error("last_of_frame: expected %b, actual %b", want.last_of_frame,
					got.last_of_frame);
				errors++;
			end
		endfunction
	endclass

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dither_scoreboard sb;
	reg_write_t       reg_writes [$];
	bit               quiet;
	int               cycles;
	int               words_sent;
	int               table_writes;
	int               phases_run;

	ordered_dither_to_mono u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("ordered_dither_to_mono regression: fail");
			$finish;
		end
	end

	// result side: check accepted words, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_word(result);
		result_stall <= !quiet && ($urandom_range(99) < 15);
	end

	function automatic item_t pixel_word(logic [PIXELS_W-1:0] px);
		item_t it;
		it.kind = KIND_PIXELS;
		it.pixels = px;
		it.table_index = IDX_W'($urandom);
		it.table_value = BYTE_W'($urandom);
		return it;
	endfunction

	function automatic item_t table_word(int idx, int value);
		item_t it;
		it.kind = KIND_TABLE;
		it.pixels = $urandom;
		it.table_index = IDX_W'(idx);
		it.table_value = BYTE_W'(value);
		return it;
	endfunction

	function automatic logic [PIXELS_W-1:0] pick_pixels();
		logic [3:0] lvl;
		lvl = 4'($urandom);
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {8{lvl}};
			3: return {16'($urandom), {8{lvl[1:0]}}};
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_row_bytes();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return MAX_COLS;
			3: return $urandom_range(MAX_COLS + 1, 1023);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_frame_rows();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return MAX_ROWS;
			3: return 8191;
			4: return $urandom_range(MAX_ROWS + 1, 8190);
			default: return $urandom_range(1, 10);
		endcase
	endfunction

	// unused upper data bits carry junk, the block must mask them
	function automatic void queue_reg(logic [CFG_IDX_W-1:0] idx, int value);
		reg_write_t w;
		logic [CFG_DATA_W-1:0] mask;
		case (idx)
			REG_ROW_BYTES:  mask = 13'h03FF;
			REG_FRAME_ROWS: mask = 13'h1FFF;
			default:        mask = 13'h0001;
		endcase
		w.idx = idx;
		w.data = (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(value) & mask);
		reg_writes.push_back(w);
	endfunction

	task automatic apply_regs();
		reg_write_t w;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.write_reg(w.idx, w.data);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic push_word(item_t it);
		if (!quiet && $urandom_range(99) < 10) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.predict_word(it);
		words_sent++;
		if (it.kind == KIND_TABLE)
			table_writes++;
	endtask

	task automatic random_word();
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(7) == 0)
				push_word(table_word($urandom_range(STORE_BYTES, 255), $urandom));
			else
				push_word(table_word($urandom_range(STORE_BYTES - 1), $urandom));
		end else begin
			push_word(pixel_word(pick_pixels()));
		end
	endtask

	// table writes give no result word, so allow the pipe to empty after the last one
	task automatic drain_results();
		item_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	initial begin
		int n;
		sb = new();
		quiet = 1'b0;
		words_sent = 0;
		table_writes = 0;
		phases_run = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one byte per row, one row per frame, 2-bit built-in table
		push_word(pixel_word(32'h0000_0000));
		push_word(pixel_word(32'hFFFF_FFFF));
		push_word(pixel_word(32'hA5A5_E4E4));

		drain_results();
		queue_reg(REG_DEPTH_MODE, 1);
		queue_reg(REG_ROW_BYTES, 2);
		queue_reg(REG_FRAME_ROWS, 3);
		apply_regs();
		push_word(pixel_word(32'h7654_3210));
		push_word(pixel_word(32'hFEDC_BA98));
		push_word(pixel_word(32'h7654_3210));
		push_word(pixel_word(32'hFEDC_BA98));
		push_word(pixel_word(32'h0F0F_F0F0));
		// writes past the store are dropped and do not move the position
		push_word(table_word(STORE_BYTES, 8'hFF));
		push_word(table_word(255, 8'h5A));
		push_word(pixel_word(32'hFFFF_FFFF));

		// row shrinks under a position already past the new end
		drain_results();
		queue_reg(REG_ROW_BYTES, 6);
		queue_reg(REG_FRAME_ROWS, 0);
		apply_regs();
		repeat (4) push_word(pixel_word(pick_pixels()));
		drain_results();
		queue_reg(REG_ROW_BYTES, 2);
		apply_regs();
		repeat (2) push_word(pixel_word(pick_pixels()));

		// fill the whole pattern store before any loaded table is read
		for (int i = 0; i < STORE_BYTES; i++)
			push_word(table_word(i, $urandom_range(255)));

		drain_results();
		queue_reg(REG_DEPTH_MODE, 0);
		queue_reg(REG_ROW_BYTES, 0);
		queue_reg(REG_FRAME_ROWS, 8);
		queue_reg(REG_CUSTOM_2, 1);
		queue_reg(REG_CUSTOM_4, 1);
		apply_regs();
		repeat (4) push_word(pixel_word(32'h0000_E4E4));
		drain_results();
		queue_reg(REG_DEPTH_MODE, 1);
		apply_regs();
		repeat (4) push_word(pixel_word(32'hFEDC_BA98));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			quiet = ($urandom_range(3) == 0);
			queue_reg(REG_DEPTH_MODE, $urandom_range(1));
			queue_reg(REG_ROW_BYTES, pick_row_bytes());
			queue_reg(REG_FRAME_ROWS, pick_frame_rows());
			queue_reg(REG_CUSTOM_2, $urandom_range(1));
			queue_reg(REG_CUSTOM_4, $urandom_range(1));
			if ($urandom_range(3) == 0)
				queue_reg(REG_UNMAPPED, $urandom);
			apply_regs();
			n = $urandom_range(35, 55);
			repeat (n) random_word();
			phases_run++;
		end

		drain_results();
		$display("covered %0d words (%0d table writes), %0d result bytes checked",
			words_sent, table_writes, sb.checked);
		$display("across %0d randomized setting phases plus directed runs",
			phases_run);
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("ordered_dither_to_mono regression: pass");
		else
			$display("ordered_dither_to_mono regression: fail");
		$finish;
	end

endmodule
